### hw/rtl/smsort_pkg.sv
// Package with the shared constants and types of the selectable-method sort engine.
package smsort_pkg;

  localparam int MAX_KEYS  = 32;
  localparam int KEY_BITS  = 16;
  localparam int DATA_W    = ((KEY_BITS + 7) / 8) * 8;
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int SETTLE_W  = $clog2(MAX_KEYS);
  localparam int METHOD_W  = 2;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic vld;
    key_t key;
  } slot_t;

  typedef struct packed {
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

  typedef enum logic [METHOD_W-1:0] {
    METHOD_BUBBLE    = 2'd0,
    METHOD_SELECTION = 2'd1,
    METHOD_INSERTION = 2'd2
  } method_t;

endpackage

### hw/rtl/smsort_cell.sv
// One compare-and-exchange cell of the sorting chain.
module smsort_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smsort_pkg::cell_ctl_t ctl,
  input  smsort_pkg::slot_t    from_left,
  input  smsort_pkg::slot_t    right_held,
  output smsort_pkg::slot_t    held,
  output smsort_pkg::slot_t    to_right
);

  smsort_pkg::slot_t held_r, held_nxt;
  smsort_pkg::slot_t pass_r, pass_nxt;

  always_comb begin
    held_nxt     = held_r;
    pass_nxt     = pass_r;
    pass_nxt.vld = 1'b0;
    if (ctl.shift) begin
      held_nxt = right_held;
    end else if (from_left.vld) begin
      if (!held_r.vld) begin
        held_nxt = from_left;
      end else if (from_left.key < held_r.key) begin
        held_nxt = from_left;
        pass_nxt = held_r;
      end else begin
        pass_nxt = from_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      held_r.vld <= held_nxt.vld;
      pass_r.vld <= pass_nxt.vld;
    end
    held_r.key <= held_nxt.key;
    pass_r.key <= pass_nxt.key;
  end

  assign held     = held_r;
  assign to_right = pass_r;

endmodule

### hw/rtl/smsort_chain.sv
// Row of sorting cells; smaller keys stay near the head, larger keys move down.
module smsort_chain (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smsort_pkg::cell_ctl_t ctl,
  input  smsort_pkg::slot_t     insert,
  output smsort_pkg::slot_t     head,
  output logic                  second_vld
);

  smsort_pkg::slot_t held_w [smsort_pkg::MAX_KEYS];
  smsort_pkg::slot_t pass_w [smsort_pkg::MAX_KEYS];

  for (genvar i = 0; i < smsort_pkg::MAX_KEYS; i++) begin : g_cell
    smsort_pkg::slot_t left_w;
    smsort_pkg::slot_t right_w;

    if (i == 0) begin : g_first
      assign left_w = insert;
    end else begin : g_mid
      assign left_w = pass_w[i-1];
    end

    if (i == smsort_pkg::MAX_KEYS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = held_w[i+1];
    end

    smsort_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .from_left  (left_w),
      .right_held (right_w),
      .held       (held_w[i]),
      .to_right   (pass_w[i])
    );
  end

  assign head       = held_w[0];
  assign second_vld = held_w[1].vld;

endmodule

### hw/rtl/selectable_method_sort_engine_top.sv
// Top level of the selectable-method sort engine: load, settle and drain control.
// A word is accepted in every cycle of a set.
// After the last word the chain settles while the largest
// keys ripple down one cell per cycle, then sorted words leave at one per cycle while out_tready is high.
// Synchronous active-low reset empties the chain, clears the count and selects bubble sort.
module selectable_method_sort_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [smsort_pkg::DATA_W-1:0]   in_tdata,  // key_value
  input  logic                            in_tlast,  // is_last
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [smsort_pkg::DATA_W-1:0]   out_tdata, // sorted_value
  output logic                            out_tlast, // final_flag
  input  logic                            cfg_we,
  input  logic [smsort_pkg::METHOD_W-1:0] cfg_wdata  // sort_method
);

  smsort_pkg::state_t                  state_r, state_nxt;
  logic [smsort_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [smsort_pkg::SETTLE_W-1:0]     settle_r, settle_nxt;
  logic [smsort_pkg::METHOD_W-1:0]     sort_method_r;
  smsort_pkg::cell_ctl_t               ctl;
  smsort_pkg::slot_t                   insert;
  smsort_pkg::slot_t                   head;
  logic                                second_vld;
  logic                                in_acc;
  logic                                out_acc;
  logic                                has_room;

  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign has_room = count_r < smsort_pkg::CNT_W'(smsort_pkg::MAX_KEYS);

  assign insert.vld = in_acc && has_room;
  assign insert.key = in_tdata[smsort_pkg::KEY_BITS-1:0];

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    settle_nxt = settle_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    ctl.shift  = 1'b0;
    case (state_r)
      smsort_pkg::ST_LOAD: begin
        in_tready = 1'b1;
        if (in_acc) begin
          if (has_room) begin
            count_nxt = count_r + 1'b1;
          end
          if (in_tlast) begin
            settle_nxt = '0;
            state_nxt  = smsort_pkg::ST_SETTLE;
          end
        end
      end
      smsort_pkg::ST_SETTLE: begin
        settle_nxt = settle_r + 1'b1;
        if (settle_r == smsort_pkg::SETTLE_W'(smsort_pkg::MAX_KEYS - 1)) begin
          state_nxt = smsort_pkg::ST_DRAIN;
        end
      end
      smsort_pkg::ST_DRAIN: begin
        out_tvalid = head.vld;
        ctl.shift  = out_acc;
        if (out_acc && !second_vld) begin
          count_nxt = '0;
          state_nxt = smsort_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = smsort_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= smsort_pkg::ST_LOAD;
      count_r       <= '0;
      settle_r      <= '0;
      sort_method_r <= smsort_pkg::METHOD_BUBBLE;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      settle_r <= settle_nxt;
      if (cfg_we) begin
        sort_method_r <= cfg_wdata;
      end
    end
  end

  smsort_chain u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .insert     (insert),
    .head       (head),
    .second_vld (second_vld)
  );

  assign out_tdata = smsort_pkg::DATA_W'(head.key);
  assign out_tlast = !second_vld;

  // Words leave the chain in ascending order within a set.
  a_ascending : assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tlast |=> out_tvalid &&
      out_tdata[smsort_pkg::KEY_BITS-1:0] >= $past(out_tdata[smsort_pkg::KEY_BITS-1:0]))
    else $error("sorted words out of order");

  // Loading and draining never overlap.
  a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while draining");

  // The set's key count never exceeds MAX_KEYS; further words of a set are not inserted.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= smsort_pkg::CNT_W'(smsort_pkg::MAX_KEYS))
    else $error("key count overflow");

  // The user must write the method register only while the engine is idle; the block does not enforce it.
  a_method_idle : assert property (@(posedge clk) disable iff (!rst_n)
    state_r != smsort_pkg::ST_LOAD |=> $stable(sort_method_r))
    else $error("sort method changed during a sort");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the selectable-method sort engine.
module tb_top;
  import smsort_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * MAX_KEYS + 8;

  typedef struct {
    key_t key;
    logic last;
  } load_word_t;

  typedef struct {
    key_t key;
    logic final_flag;
  } sorted_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic                out_tlast;
  logic                cfg_we = 1'b0;
  logic [METHOD_W-1:0] cfg_wdata = '0;

  load_word_t   load_words_q[$];
  sorted_word_t sorted_keys_q[$];
  key_t         set_keys[MAX_KEYS];
  int           set_count;
  logic [METHOD_W-1:0] method_mirror;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int words_in = 0;
  int words_out = 0;
  int sets_done = 0;
  int overfull_sets = 0;

  selectable_method_sort_engine_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic load_key(input key_t key, input logic last);
    key_t held;
    int   pos;
    int   best;
    if (set_count < MAX_KEYS) begin
      set_keys[set_count] = key;
      set_count++;
    end
    if (last) begin
      case (method_mirror)
        METHOD_BUBBLE: begin
          for (int p = 0; p + 1 < set_count; p++) begin
            for (int j = 0; j + 1 < set_count - p; j++) begin
              if (set_keys[j] > set_keys[j+1]) begin
                held = set_keys[j];
                set_keys[j] = set_keys[j+1];
                set_keys[j+1] = held;
              end
            end
          end
        end
        METHOD_SELECTION: begin
          for (int i = 0; i < set_count; i++) begin
            best = i;
            for (int j = i; j < set_count; j++) begin
              if (set_keys[j] < set_keys[best]) best = j;
            end
            held = set_keys[i];
            set_keys[i] = set_keys[best];
            set_keys[best] = held;
          end
        end
        default: begin
          for (int i = 1; i < set_count; i++) begin
            held = set_keys[i];
            pos = i;
            while (pos > 0 && held < set_keys[pos-1]) begin
              set_keys[pos] = set_keys[pos-1];
              pos--;
            end
            set_keys[pos] = held;
          end
        end
      endcase
      for (int k = 0; k < set_count; k++) begin
        sorted_keys_q.push_back('{set_keys[k], (k + 1 == set_count)});
      end
      set_count = 0;
      sets_done++;
    end
  endtask

  always @(posedge clk) begin
    load_word_t w;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (load_words_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = load_words_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= w.key;
        in_tlast  <= w.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sorted_word_t exp_w;
    logic         moved;
    if (!rst_n) begin
      method_mirror = METHOD_BUBBLE;
      set_count = 0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we) method_mirror = cfg_wdata;
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        words_in++;
        load_key(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        words_out++;
        if (sorted_keys_q.size() == 0) begin
          $error("unexpected word: sorted_value %h final_flag %b", out_tdata, out_tlast);
          mismatches++;
        end else begin
          exp_w = sorted_keys_q.pop_front();
          if (out_tdata !== exp_w.key) begin
            $error("sorted_value: expected %h, actual %h", exp_w.key, out_tdata);
            mismatches++;
          end
          if (out_tlast !== exp_w.final_flag) begin
            $error("final_flag: expected %b, actual %b", exp_w.final_flag, out_tlast);
            mismatches++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d words still expected.", sorted_keys_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic key_t pick_key();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return key_t'($urandom_range(3));
      default: return key_t'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic queue_set(input int n);
    for (int i = 0; i < n; i++) begin
      load_words_q.push_back('{pick_key(), (i == n - 1)});
    end
    if (n > MAX_KEYS) overfull_sets++;
  endtask

  task automatic queue_keys(input key_t keys[$]);
    foreach (keys[i]) load_words_q.push_back('{keys[i], (i == keys.size() - 1)});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (load_words_q.size() != 0 || in_tvalid || sorted_keys_q.size() != 0);
  endtask

  initial begin
    int phase_words;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 16; ph++) begin
      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= METHOD_W'(ph / 4);
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      case (ph % 4)
        1:       send_idle_pct = 88;
        2:       recv_stall_pct = 88;
        3:       begin send_idle_pct = 38; recv_stall_pct = 38; end
        default: ;
      endcase
      if (ph == 0) begin
        queue_keys('{16'h0000});
        queue_keys('{16'hFFFF});
        queue_keys('{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'hFFFF, 16'h0000});
        queue_keys('{16'h0001, 16'h0002, 16'h0003, 16'h0004});
        queue_keys('{16'hAAAA, 16'h5555, 16'h0F0F, 16'h00F0, 16'h0001});
        queue_keys('{16'h1234, 16'h1234});
      end
      if (ph % 5 == 2) queue_set(MAX_KEYS);
      if (ph % 5 == 0 && ph > 0) queue_set($urandom_range(MAX_KEYS + 1, MAX_KEYS + 6));
      phase_words = 0;
      while (phase_words < 10) begin
        int n;
        n = $urandom_range(1, 8);
        queue_set(n);
        phase_words += n;
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sorted %0d sets (%0d words in, %0d words out), %0d of them overfilled,",
             sets_done, words_in, words_out, overfull_sets);
    $display("under all four method codes with free-running and stalled handshakes.");
    if (mismatches == 0 && sorted_keys_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
